// ===== rtl/core/rsws_pkg.sv =====
// shared constants and types for the range split work stealer
`default_nettype none
package rsws_pkg;
  localparam int MAX_CONNS = 16;
  localparam int OFS_BITS  = 48;
  localparam int IDX_W     = $clog2(MAX_CONNS);
  localparam int CNT_W     = $clog2(MAX_CONNS + 1);
  localparam int CHUNK_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFGI_W    = 2;

  localparam logic [CNT_W-1:0]   RESET_REQ   = CNT_W'(4);
  localparam logic [CHUNK_W-1:0] RESET_CHUNK = CHUNK_W'(100 * 1024);

  localparam logic [1:0] FUNC_DIVIDE   = 2'd0;
  localparam logic [1:0] FUNC_PROGRESS = 2'd1;
  localparam logic [1:0] FUNC_STEAL    = 2'd2;

  localparam logic [CFGI_W-1:0] REG_REQ   = CFGI_W'(0);
  localparam logic [CFGI_W-1:0] REG_CHUNK = CFGI_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_Q1, S_W1, S_Q2, S_W2, S_Q3, S_W3, S_WRITE,
    S_SCHK, S_SCAN, S_APPLY, S_ONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/rsws_if.sv =====
// item channels of the range split work stealer
`default_nettype none
interface rsws_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      func;
  logic [rsws_pkg::OFS_BITS-1:0]   file_size;
  logic [rsws_pkg::IDX_W-1:0]      conn_index;
  logic [rsws_pkg::OFS_BITS-1:0]   position;
  logic                            active;
  modport source (output valid, func, file_size, conn_index, position, active, input ready);
  modport sink (input valid, func, file_size, conn_index, position, active, output ready);
endinterface

interface rsws_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rsws_pkg::IDX_W-1:0]      seg_index;
  logic [rsws_pkg::OFS_BITS-1:0]   range_start;
  logic [rsws_pkg::OFS_BITS-1:0]   range_end;
  logic [rsws_pkg::IDX_W-1:0]      donor_index;
  logic                            changed;
  logic [rsws_pkg::CNT_W-1:0]      in_use;
  logic                            last;
  modport source (output valid, seg_index, range_start, range_end, donor_index, changed,
                  in_use, last, input ready);
  modport sink (input valid, seg_index, range_start, range_end, donor_index, changed,
                in_use, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsws_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rsws_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rsws_pkg::OFS_BITS-1:0] dividend,
  input  wire logic [rsws_pkg::OFS_BITS-1:0] divisor,
  output logic                               done,
  output logic [rsws_pkg::OFS_BITS-1:0]      quotient,
  output logic [rsws_pkg::OFS_BITS-1:0]      remainder
);
  import rsws_pkg::*;
  localparam int CW = $clog2(OFS_BITS);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [OFS_BITS-1:0] dsr;
  logic [OFS_BITS:0]   shifted;
  logic [OFS_BITS:0]   diff;

  assign shifted = {remainder, quotient[OFS_BITS-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        remainder <= '0;
        quotient  <= dividend;
        dsr       <= divisor;
      end else if (busy) begin
        if (!diff[OFS_BITS]) begin
          remainder <= diff[OFS_BITS-1:0];
          quotient  <= {quotient[OFS_BITS-2:0], 1'b1};
        end else begin
          remainder <= shifted[OFS_BITS-1:0];
          quotient  <= {quotient[OFS_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(OFS_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/range_split_work_stealer_core.sv =====
// top level: range table, sequencer and shared divider
// divide: up to three divisions in the shared divider, then one write per range
// progress: SCHK, ONE; steal: SCHK, scan of in_use entries if needed, ONE/APPLY
// one item at a time; cmd.ready is low until the last result is registered
// an output register holds each result until rsp.ready
// synchronous reset clears the table, sets in_use to 1, requested 4, chunk 102400
`default_nettype none
module range_split_work_stealer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rsws_cmd_if.sink                           cmd,
  rsws_rsp_if.source                         rsp,
  input  wire logic                          cfg_we,
  input  wire logic [rsws_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [rsws_pkg::CFG_W-1:0]    cfg_data
);
  import rsws_pkg::*;

  state_t state, state_next;

  logic [OFS_BITS-1:0] first_q [MAX_CONNS];
  logic [OFS_BITS-1:0] limit_q [MAX_CONNS];
  logic                busy_q  [MAX_CONNS];
  logic [CNT_W-1:0]    conns_in_use;
  logic [CNT_W-1:0]    req_conns;
  logic [CHUNK_W-1:0]  min_chunk;

  logic [1:0]          func_r;
  logic [OFS_BITS-1:0] size_r, pos_r, seg, tail, acc, best;
  logic [IDX_W-1:0]    idx_r, donor;
  logic                act_r, found;
  logic [CNT_W-1:0]    n, cnt;

  logic                out_v, out_chg, out_last, out_load;
  logic [IDX_W-1:0]    out_idx, out_donor;
  logic [OFS_BITS-1:0] out_start, out_end;
  logic [CNT_W-1:0]    out_use;

  logic                div_start, div_done;
  logic [OFS_BITS-1:0] div_dsr, div_q, div_r;

  logic [CHUNK_W-1:0]  chunk_eff;
  logic [CNT_W-1:0]    req_eff;
  logic [IDX_W-1:0]    rd_addr;
  logic [OFS_BITS-1:0] rd_first, rd_limit, rd_rem, half_pt, wr_lim;
  logic                rd_busy, can_load, accept, idx_bad, is_last;

  assign chunk_eff = (min_chunk == '0) ? CHUNK_W'(1) : min_chunk;
  assign req_eff   = (req_conns == '0) ? CNT_W'(1) :
                     (req_conns > CNT_W'(MAX_CONNS)) ? CNT_W'(MAX_CONNS) : req_conns;
  assign can_load  = !out_v || rsp.ready;
  assign out_load  = can_load && (state == S_WRITE || state == S_ONE || state == S_APPLY);
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign idx_bad   = ({1'b0, idx_r} >= (IDX_W + 1)'(MAX_CONNS));
  assign is_last   = (cnt + 1'b1 == n);

  always_comb begin
    case (state)
      S_SCAN:  rd_addr = cnt[IDX_W-1:0];
      S_APPLY: rd_addr = donor;
      default: rd_addr = idx_r;
    endcase
  end
  assign rd_first = first_q[rd_addr];
  assign rd_limit = limit_q[rd_addr];
  assign rd_busy  = busy_q[rd_addr];
  assign rd_rem   = rd_limit - rd_first;
  assign half_pt  = rd_first + (best >> 1);
  assign wr_lim   = acc + seg + (is_last ? tail : '0);

  always_comb begin
    case (state)
      S_Q1:    div_dsr = OFS_BITS'(chunk_eff);
      S_Q2:    div_dsr = OFS_BITS'(n);
      default: div_dsr = seg;
    endcase
  end
  assign div_start = (state == S_Q1) || (state == S_Q2) || (state == S_Q3);

  rsws_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(size_r), .divisor(div_dsr),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.func == FUNC_DIVIDE) state_next = S_Q1;
          else if (cmd.func == FUNC_PROGRESS || cmd.func == FUNC_STEAL) state_next = S_SCHK;
        end
      end
      S_Q1:    state_next = S_W1;
      S_W1:    if (div_done) state_next = S_Q2;
      S_Q2:    state_next = S_W2;
      S_W2: begin
        if (div_done) state_next = (div_q == '0 && size_r == '0) ? S_WRITE : S_Q3;
      end
      S_Q3:    state_next = S_W3;
      S_W3:    if (div_done) state_next = S_WRITE;
      S_WRITE: if (can_load && is_last) state_next = S_IDLE;
      S_SCHK: begin
        if (idx_bad || func_r == FUNC_PROGRESS || rd_busy || rd_first < rd_limit) begin
          state_next = S_ONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: if (cnt + 1'b1 >= conns_in_use) state_next = S_ONE;
      S_ONE:  if (can_load) state_next = S_IDLE;
      S_APPLY: if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_SCAN && cnt + 1'b1 >= conns_in_use &&
        (found || (rd_limit > rd_first && rd_rem > best))) begin
      state_next = S_APPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_conns    <= RESET_REQ;
      min_chunk    <= RESET_CHUNK;
      conns_in_use <= CNT_W'(1);
      out_v        <= 1'b0;
      for (int k = 0; k < MAX_CONNS; k++) begin
        first_q[k] <= '0;
        limit_q[k] <= '0;
        busy_q[k]  <= 1'b0;
      end
    end else begin
      if (cfg_we && cfg_index == REG_REQ) req_conns <= cfg_data[CNT_W-1:0];
      if (cfg_we && cfg_index == REG_CHUNK) min_chunk <= cfg_data[CHUNK_W-1:0];
      if (out_load) out_v <= 1'b1;
      else if (rsp.ready) out_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_r <= cmd.func;
            size_r <= cmd.file_size;
            idx_r  <= cmd.conn_index;
            pos_r  <= cmd.position;
            act_r  <= cmd.active;
          end
        end
        S_W1: begin
          if (div_done) begin
            if (div_q == '0) n <= CNT_W'(1);
            else if (div_q < OFS_BITS'(req_eff)) n <= div_q[CNT_W-1:0];
            else n <= req_eff;
          end
        end
        S_W2: begin
          if (div_done) begin
            acc  <= '0;
            cnt  <= '0;
            tail <= '0;
            if (div_q == '0) begin
              n            <= CNT_W'(1);
              seg          <= size_r;
              conns_in_use <= CNT_W'(1);
            end else begin
              seg          <= div_q;
              conns_in_use <= n;
            end
          end
        end
        S_W3: if (div_done) tail <= div_r;
        S_WRITE: begin
          if (can_load) begin
            first_q[cnt[IDX_W-1:0]] <= acc;
            limit_q[cnt[IDX_W-1:0]] <= wr_lim;
            out_idx   <= cnt[IDX_W-1:0];
            out_start <= acc;
            out_end   <= wr_lim;
            out_donor <= '0;
            out_chg   <= 1'b1;
            out_use   <= conns_in_use;
            out_last  <= is_last;
            acc       <= acc + seg;
            cnt       <= cnt + 1'b1;
          end
        end
        S_SCHK: begin
          best  <= OFS_BITS'(chunk_eff - 1'b1);
          found <= 1'b0;
          donor <= '0;
          cnt   <= '0;
          if (!idx_bad && func_r == FUNC_PROGRESS) begin
            first_q[idx_r] <= pos_r;
            busy_q[idx_r]  <= act_r;
          end
        end
        S_SCAN: begin
          if (rd_limit > rd_first && rd_rem > best) begin
            best  <= rd_rem;
            donor <= cnt[IDX_W-1:0];
            found <= 1'b1;
          end
          cnt <= cnt + 1'b1;
        end
        S_ONE: begin
          if (can_load) begin
            out_idx   <= idx_r;
            out_start <= idx_bad ? '0 : rd_first;
            out_end   <= idx_bad ? '0 : rd_limit;
            out_donor <= '0;
            out_chg   <= !idx_bad && func_r == FUNC_PROGRESS;
            out_use   <= conns_in_use;
            out_last  <= 1'b1;
          end
        end
        S_APPLY: begin
          if (can_load) begin
            limit_q[idx_r] <= rd_limit;
            first_q[idx_r] <= half_pt;
            limit_q[donor] <= half_pt;
            out_idx   <= idx_r;
            out_start <= half_pt;
            out_end   <= rd_limit;
            out_donor <= donor;
            out_chg   <= 1'b1;
            out_use   <= conns_in_use;
            out_last  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.seg_index   = out_idx;
  assign rsp.range_start = out_start;
  assign rsp.range_end   = out_end;
  assign rsp.donor_index = out_donor;
  assign rsp.changed     = out_chg;
  assign rsp.in_use      = out_use;
  assign rsp.last        = out_last;

  a_in_use_range: assert property (@(posedge clk) disable iff (rst)
    conns_in_use != '0 && conns_in_use <= CNT_W'(MAX_CONNS))
    else $error("in_use out of range");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_W1 || state == S_W2 || state == S_W3))
    else $error("divider finished outside a wait state");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd.ready)
    else $error("item taken while busy");
  a_steal_donor: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> found || $past(state) == S_SCAN)
    else $error("steal applied without a donor");
endmodule
`default_nettype wire
